// ===== hdl/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// shared types and constants for the message field splitter
// ----------------------------------------------------------------------------
package mfs_pkg;

  // character codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // field kinds
  localparam logic [2:0] KIND_PREFIX = 3'd0;
  localparam logic [2:0] KIND_CMD    = 3'd1;
  localparam logic [2:0] KIND_PARAM  = 3'd2;
  localparam logic [2:0] KIND_TRAIL  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // end marker status
  localparam logic STATUS_VALID   = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // parameters completed before later tokens are dropped
  localparam logic [3:0] PARAM_LIMIT = 4'd15;

  // result queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic [3:0] param_index;
    logic       field_start;
    logic       status;
  } mfs_item_t;

endpackage

// ===== hdl/mfs_front.sv =====
// ----------------------------------------------------------------------------
// mfs_front
// accepts stream bytes, tracks the line phase and classifies each byte
// ----------------------------------------------------------------------------
module mfs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              q_push,
  output mfs_pkg::mfs_item_t q_push_item
);
  import mfs_pkg::*;

  localparam logic [3:0] PH_LEAD      = 4'd0;
  localparam logic [3:0] PH_PREFIX    = 4'd1;
  localparam logic [3:0] PH_GAP_CMD   = 4'd2;
  localparam logic [3:0] PH_CMD       = 4'd3;
  localparam logic [3:0] PH_GAP_PARAM = 4'd4;
  localparam logic [3:0] PH_PARAM     = 4'd5;
  localparam logic [3:0] PH_TRAIL_BEG = 4'd6;
  localparam logic [3:0] PH_TRAIL     = 4'd7;
  localparam logic [3:0] PH_DROP      = 4'd8;

  logic [3:0] phase_r, phase_nxt;
  logic [3:0] param_count_r, param_count_nxt;
  logic       content_r, content_nxt;
  logic       emit;
  logic       accept;
  logic       is_eol;
  logic       is_space;
  logic       is_colon;
  mfs_item_t  item;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_eol   = (in_data_byte == CHAR_CR) || (in_data_byte == CHAR_LF);
  assign is_space = (in_data_byte == CHAR_SPACE);
  assign is_colon = (in_data_byte == CHAR_COLON);

  always_comb begin
    phase_nxt        = phase_r;
    param_count_nxt  = param_count_r;
    content_nxt      = content_r;
    emit             = 1'b0;
    item.out_byte    = in_data_byte;
    item.field_kind  = KIND_PREFIX;
    item.param_index = 4'd0;
    item.field_start = 1'b0;
    item.status      = STATUS_VALID;
    if (is_eol) begin
      emit            = content_r;
      item.out_byte   = 8'd0;
      item.field_kind = KIND_END;
      item.status     = (phase_r >= PH_CMD && phase_r <= PH_DROP) ?
                        STATUS_VALID : STATUS_INVALID;
      phase_nxt       = PH_LEAD;
      param_count_nxt = 4'd0;
      content_nxt     = 1'b0;
    end else begin
      content_nxt = 1'b1;
      case (phase_r)
        PH_LEAD: begin
          if (!is_space) begin
            emit             = 1'b1;
            item.field_start = 1'b1;
            if (is_colon) begin
              phase_nxt       = PH_PREFIX;
              item.field_kind = KIND_PREFIX;
            end else begin
              phase_nxt       = PH_CMD;
              item.field_kind = KIND_CMD;
            end
          end
        end
        PH_PREFIX: begin
          if (is_space) begin
            phase_nxt = PH_GAP_CMD;
          end else begin
            emit            = 1'b1;
            item.field_kind = KIND_PREFIX;
          end
        end
        PH_GAP_CMD: begin
          if (!is_space) begin
            phase_nxt        = PH_CMD;
            emit             = 1'b1;
            item.field_kind  = KIND_CMD;
            item.field_start = 1'b1;
          end
        end
        PH_CMD: begin
          if (is_space) begin
            phase_nxt = PH_GAP_PARAM;
          end else begin
            emit            = 1'b1;
            item.field_kind = KIND_CMD;
          end
        end
        PH_GAP_PARAM: begin
          if (!is_space) begin
            if (param_count_r >= PARAM_LIMIT) begin
              phase_nxt = PH_DROP;
            end else if (is_colon) begin
              phase_nxt = PH_TRAIL_BEG;
            end else begin
              phase_nxt        = PH_PARAM;
              emit             = 1'b1;
              item.field_kind  = KIND_PARAM;
              item.param_index = param_count_r;
              item.field_start = 1'b1;
            end
          end
        end
        PH_PARAM: begin
          if (is_space) begin
            param_count_nxt = param_count_r + 4'd1;
            phase_nxt       = PH_GAP_PARAM;
          end else begin
            emit             = 1'b1;
            item.field_kind  = KIND_PARAM;
            item.param_index = param_count_r;
          end
        end
        PH_TRAIL_BEG: begin
          phase_nxt        = PH_TRAIL;
          emit             = 1'b1;
          item.field_kind  = KIND_TRAIL;
          item.field_start = 1'b1;
        end
        PH_TRAIL: begin
          emit            = 1'b1;
          item.field_kind = KIND_TRAIL;
        end
        default: begin
          phase_nxt = PH_DROP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEAD;
      param_count_r <= 4'd0;
      content_r     <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      param_count_r <= param_count_nxt;
      content_r     <= content_nxt;
    end
  end

  assign q_push      = accept && emit;
  assign q_push_item = item;

endmodule

// ===== hdl/mfs_queue.sv =====
// ----------------------------------------------------------------------------
// mfs_queue
// short result queue that decouples the classifier from the output stage
// ----------------------------------------------------------------------------
module mfs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mfs_pkg::mfs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output mfs_pkg::mfs_item_t pop_item
);
  import mfs_pkg::*;

  mfs_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/mfs_back.sv =====
// ----------------------------------------------------------------------------
// mfs_back
// output register that drains the result queue onto the result channel
// ----------------------------------------------------------------------------
module mfs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  mfs_pkg::mfs_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [2:0]         out_field_kind,
  output logic [3:0]         out_param_index,
  output logic               out_field_start,
  output logic               out_status
);
  import mfs_pkg::*;

  logic      valid_r, valid_nxt;
  mfs_item_t item_r;
  logic      load;

  assign load  = q_not_empty && (!valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_item;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = item_r.out_byte;
  assign out_field_kind  = item_r.field_kind;
  assign out_param_index = item_r.param_index;
  assign out_field_start = item_r.field_start;
  assign out_status      = item_r.status;

endmodule

// ===== hdl/irc_message_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// irc_message_field_splitter_unit
// splits a line-oriented text stream into tagged prefix, command, parameter
// and trailing bytes, with one end marker per non-empty line
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and sustains one byte per clock cycle while
// the queue is not full: the only state carried from byte to byte is the line
// phase, the parameter count and a content flag, all registered in the front.
// Each byte gives at most one result beat, which goes through a two-entry queue
// into the output register. The input is stalled only while the queue is full,
// so while the result side stalls, the output register and the queue take
// three result beats before the input is held.
module irc_message_field_splitter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_field_kind,
  output logic [3:0] out_param_index,
  output logic       out_field_start,
  output logic       out_status
);
  import mfs_pkg::*;

  logic      q_full;
  logic      q_push;
  mfs_item_t q_push_item;
  logic      q_pop;
  logic      q_not_empty;
  mfs_item_t q_pop_item;

  mfs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_item  (q_push_item)
  );

  mfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_pop_item)
  );

  mfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_item          (q_pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_field_kind  (out_field_kind),
    .out_param_index (out_param_index),
    .out_field_start (out_field_start),
    .out_status      (out_status)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the message field splitter against a cycle-free line parser
// ----------------------------------------------------------------------------
// Bytes are queued up front: a short directed set of lines first, then
// random lines. Most random lines are well-formed, with prefix, command,
// parameters and trailing text. The rest is noise. Both channels idle at
// random, with one quiet stretch and one long hold-off on the result side.
// Every accepted byte goes through the parser model here, and each result
// beat is compared field by field with the oldest expected beat.
// ----------------------------------------------------------------------------
module tb;
  import mfs_pkg::*;

  localparam int ITEM_TARGET  = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_FROM   = 900;
  localparam int QUIET_TO     = 1300;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 150;

  typedef enum logic [3:0] {
    LINE_LEAD, IN_PREFIX, GAP_CMD, IN_CMD, GAP_PARAM, IN_PARAM,
    TRAIL_BEGIN, IN_TRAIL, DROPPING
  } line_phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_field_kind;
  logic [3:0] out_param_index;
  logic       out_field_start;
  logic       out_status;

  logic [7:0]  pending_bytes[$];
  mfs_item_t   expected_beats[$];
  logic        in_took = 1'b0;
  int          cyc = 0;
  int          errs = 0;
  int          hold_left = 0;

  line_phase_t ph = LINE_LEAD;
  logic [3:0]  params_done = 4'd0;
  logic        line_seen = 1'b0;

  irc_message_field_splitter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_field_kind  (out_field_kind),
    .out_param_index (out_param_index),
    .out_field_start (out_field_start),
    .out_status      (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic mfs_item_t tag(logic [7:0] b, logic [2:0] kind, logic [3:0] idx,
                                    logic first);
    mfs_item_t r;
    r.out_byte    = b;
    r.field_kind  = kind;
    r.param_index = idx;
    r.field_start = first;
    r.status      = STATUS_VALID;
    return r;
  endfunction

  task automatic split_byte(input logic [7:0] b, output bit made, output mfs_item_t r);
    made = 1'b0;
    r = '0;
    if (b == CHAR_CR || b == CHAR_LF) begin
      if (line_seen) begin
        made = 1'b1;
        r.field_kind = KIND_END;
        r.status = (ph >= IN_CMD) ? STATUS_VALID : STATUS_INVALID;
      end
      ph = LINE_LEAD;
      params_done = 4'd0;
      line_seen = 1'b0;
    end else begin
      line_seen = 1'b1;
      case (ph)
        LINE_LEAD: begin
          if (b == CHAR_COLON) begin
            ph = IN_PREFIX;
            made = 1'b1;
            r = tag(b, KIND_PREFIX, 4'd0, 1'b1);
          end else if (b != CHAR_SPACE) begin
            ph = IN_CMD;
            made = 1'b1;
            r = tag(b, KIND_CMD, 4'd0, 1'b1);
          end
        end
        IN_PREFIX: begin
          if (b == CHAR_SPACE) begin
            ph = GAP_CMD;
          end else begin
            made = 1'b1;
            r = tag(b, KIND_PREFIX, 4'd0, 1'b0);
          end
        end
        GAP_CMD: begin
          if (b != CHAR_SPACE) begin
            ph = IN_CMD;
            made = 1'b1;
            r = tag(b, KIND_CMD, 4'd0, 1'b1);
          end
        end
        IN_CMD: begin
          if (b == CHAR_SPACE) begin
            ph = GAP_PARAM;
          end else begin
            made = 1'b1;
            r = tag(b, KIND_CMD, 4'd0, 1'b0);
          end
        end
        GAP_PARAM: begin
          if (b != CHAR_SPACE) begin
            if (params_done >= PARAM_LIMIT) begin
              ph = DROPPING;
            end else if (b == CHAR_COLON) begin
              ph = TRAIL_BEGIN;
            end else begin
              ph = IN_PARAM;
              made = 1'b1;
              r = tag(b, KIND_PARAM, params_done, 1'b1);
            end
          end
        end
        IN_PARAM: begin
          if (b == CHAR_SPACE) begin
            params_done = params_done + 4'd1;
            ph = GAP_PARAM;
          end else begin
            made = 1'b1;
            r = tag(b, KIND_PARAM, params_done, 1'b0);
          end
        end
        TRAIL_BEGIN: begin
          ph = IN_TRAIL;
          made = 1'b1;
          r = tag(b, KIND_TRAIL, 4'd0, 1'b1);
        end
        IN_TRAIL: begin
          made = 1'b1;
          r = tag(b, KIND_TRAIL, 4'd0, 1'b0);
        end
        default: ph = DROPPING;
      endcase
    end
  endtask

  task automatic push_byte(logic [7:0] b);
    pending_bytes.push_back(b);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    repeat (n) push_byte(CHAR_SPACE);
  endtask

  function automatic logic [7:0] tok_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(33, 126));
    end while (c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  task automatic push_token();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) push_byte(tok_char());
  endtask

  task automatic push_random_line();
    int pick;
    int n_par;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      n = $urandom_range(1, 16);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0: push_byte(CHAR_SPACE);
          1: push_byte(CHAR_COLON);
          2: push_byte(CHAR_CR);
          3: push_byte(CHAR_LF);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    if ($urandom_range(0, 3) == 0) push_gap();
    if ($urandom_range(0, 1) == 1) begin
      push_byte(CHAR_COLON);
      if ($urandom_range(0, 4) != 0) push_token();
      if (pick >= 95) begin
        if ($urandom_range(0, 1) == 1) push_gap();
        push_byte(CHAR_LF);
        return;
      end
      push_gap();
    end
    push_token();
    n_par = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
    repeat (n_par) begin
      push_gap();
      push_token();
    end
    if ($urandom_range(0, 1) == 1) begin
      push_gap();
      push_byte(CHAR_COLON);
      n = $urandom_range(0, 8);
      repeat (n) push_byte(($urandom_range(0, 3) == 0) ? CHAR_SPACE : tok_char());
    end
    if ($urandom_range(0, 9) == 0) push_gap();
    case ($urandom_range(0, 2))
      0: push_byte(CHAR_CR);
      1: push_byte(CHAR_LF);
      default: begin
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end
    endcase
  endtask

  function automatic bit idle_roll();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 31;
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_bytes.size() != 0 && !idle_roll()) begin
        in_valid <= 1'b1;
        in_data_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin
    if (cyc == HOLD_AT) hold_left <= HOLD_LEN;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_left != 0 || cyc == HOLD_AT) out_stall <= 1'b1;
    else out_stall <= idle_roll();
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    mfs_item_t want;
    mfs_item_t got;
    bit made;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      split_byte(in_data_byte, made, want);
      if (made) expected_beats.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_byte, out_field_kind, out_param_index, out_field_start, out_status};
      if (expected_beats.size() == 0) begin
        errs++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      end else begin
        want = expected_beats.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("field_kind", want.field_kind, got.field_kind);
        check_field("param_index", want.param_index, got.param_index);
        check_field("field_start", want.field_start, got.field_start);
        check_field("status", want.status, got.status);
      end
    end
  end

  initial begin
    // crlf line with prefix-less command, params and trailing with spaces
    push_text("CMD a b :hi there");
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    // blank lines
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    // spaces only
    push_text("   ");
    push_byte(CHAR_LF);
    // prefix alone
    push_text(":pfx");
    push_byte(CHAR_LF);
    // colon token after prefix is the command
    push_text(":p  :cmd x");
    push_byte(CHAR_CR);
    // empty trailing after leading spaces
    push_text("  C :");
    push_byte(CHAR_LF);
    // parameter limit, later tokens dropped
    push_text("P a b c d e f g h i j k l m n o p :t");
    push_byte(CHAR_LF);
    // zero and all-ones bytes as content
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_SPACE);
    push_byte(8'h80);
    push_text(" :");
    push_byte(8'h7F);
    push_byte(CHAR_LF);
    while (pending_bytes.size() < ITEM_TARGET) push_random_line();
    push_byte(CHAR_LF);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (cyc < CYCLE_LIMIT &&
           !(pending_bytes.size() == 0 && !in_valid && expected_beats.size() == 0))
      @(negedge clk);
    if (cyc >= CYCLE_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (errs == 0 && expected_beats.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mfs_pkg.sv
hdl/mfs_front.sv
hdl/mfs_queue.sv
hdl/mfs_back.sv
hdl/irc_message_field_splitter_unit.sv
sim/tb.sv
